// File: hw/rtl/ptc_pkg.sv
// Shared constants and helpers for the pressure/temperature compensation core.
// No dependencies.
package ptc_pkg;

    // Fixed constants of the compensation algorithm
    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] X3_OFFSET   = 32'd32768;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] T1_COEF     = 32'd3038;
    localparam logic [31:0] T2_COEF_NEG = 32'hFFFF_E343;   // -7357
    localparam logic [31:0] P_OFFSET    = 32'd3791;

    // Configuration register indexes
    localparam logic [1:0] CFG_CAL_A = 2'd0;
    localparam logic [1:0] CFG_CAL_B = 2'd1;
    localparam logic [1:0] CFG_CAL_C = 2'd2;
    localparam logic [1:0] CFG_OSS   = 2'd3;

    typedef logic [31:0] word_t;

    // Arithmetic right shift by a constant amount
    function automatic word_t asr(input word_t v, input logic [4:0] sh);
        return word_t'($signed(v) >>> sh);
    endfunction

    function automatic word_t sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic word_t mag(input word_t v);
        return v[31] ? (word_t'(0) - v) : v;
    endfunction

endpackage

// File: hw/rtl/pressure_temperature_compensation_core.sv
// Pressure/temperature compensation core: sequencer around one shared
// bit-serial multiplier / restoring divider. Depends on ptc_pkg.
//
// Channel | Dir | Beat contents
// s_      | in  | tuser: kind ; tdata[23:0]: raw_reading
// m_      | out | tuser[0]: kind_echo, tuser[1]: divide_fault ; tdata: value
// cfg_    | in  | write enable, register index, 64-bit data
//
// Every multiply and divide runs through the shared serial unit, one bit a cycle, with
// a sequencer step between operations. A temperature beat takes two serial operations,
// a pressure beat eleven; a zero divisor skips the divide and all serial operations
// after it.
// Reset is synchronous, active low; it clears control, configuration and stored b5.
// One beat is worked at a time; a finished result waits in the output register while
// the next beat is taken in.
module pressure_temperature_compensation_core import ptc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,        // [0] kind
    input  logic [23:0] s_tdata,        // [23:0] raw_reading
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,        // [0] kind_echo, [1] divide_fault
    output logic [31:0] m_tdata,        // [31:0] value
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    localparam logic [3:0] S_IDLE = 4'd0,  S_RUN = 4'd1,  S_DONE = 4'd2,  S_T1 = 4'd3,
                           S_T2   = 4'd4,  S_P1  = 4'd5,  S_P2   = 4'd6,  S_P3 = 4'd7,
                           S_P4   = 4'd8,  S_P5  = 4'd9,  S_P6   = 4'd10, S_P7 = 4'd11,
                           S_P8   = 4'd12, S_P9  = 4'd13, S_P10  = 4'd14, S_P11 = 4'd15;

    logic [63:0] cal_a_reg, cal_b_reg;
    logic [47:0] cal_c_reg;
    logic [1:0]  oss_reg;
    word_t       b5_reg, b5_next;

    logic [3:0]  state_reg, state_next, ret_reg, ret_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        div_reg, div_next;
    word_t       opa_reg, opa_next, opb_reg, opb_next, acc_reg, acc_next;
    word_t       x_reg, x_next, y_reg, y_next, z_reg, z_next, w_reg, w_next;
    logic        neg_reg, neg_next, fault_reg, fault_next;
    logic        kind_reg, kind_next;
    logic [23:0] raw_reg, raw_next;
    word_t       val_reg, val_next;
    logic        ovld_reg, ovld_next;
    word_t       odata_reg, odata_next;
    logic [1:0]  ouser_reg, ouser_next;

    word_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(cal_a_reg[63:48]);
    assign ac2 = sx16(cal_a_reg[47:32]);
    assign ac3 = sx16(cal_a_reg[31:16]);
    assign ac4 = {16'd0, cal_a_reg[15:0]};
    assign ac5 = {16'd0, cal_b_reg[63:48]};
    assign ac6 = {16'd0, cal_b_reg[47:32]};
    assign b1  = sx16(cal_b_reg[31:16]);
    assign b2  = sx16(cal_b_reg[15:0]);
    assign mc  = sx16(cal_c_reg[31:16]);
    assign md  = sx16(cal_c_reg[15:0]);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovld_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

    // serial unit: shift-add multiply or restoring divide, one bit a cycle
    logic [32:0] dshift, dtrial;
    assign dshift = {acc_reg, opb_reg[31]};
    assign dtrial = dshift - {1'b0, opa_reg};

    word_t t_a, t_b, t_c, up;
    always_comb begin
        state_next = state_reg; ret_next = ret_reg; cnt_next = cnt_reg; div_next = div_reg;
        opa_next = opa_reg; opb_next = opb_reg; acc_next = acc_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg; w_next = w_reg;
        neg_next = neg_reg; fault_next = fault_reg; kind_next = kind_reg;
        raw_next = raw_reg; val_next = val_reg; b5_next = b5_reg;
        ovld_next = ovld_reg; odata_next = odata_reg; ouser_next = ouser_reg;
        t_a = '0; t_b = '0; t_c = '0;
        up = word_t'(raw_reg >> (4'd8 - {2'b00, oss_reg}));

        if (ovld_reg && m_tready) ovld_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    raw_next   = s_tdata;
                    fault_next = 1'b0;
                    val_next   = '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    div_next   = 1'b0;
                    state_next = S_RUN;
                    if (!s_tuser) begin
                        opa_next = {16'd0, s_tdata[15:0]} - ac6;
                        opb_next = ac5;
                        ret_next = S_T1;
                    end else begin
                        t_a      = b5_reg - B6_OFFSET;
                        x_next   = t_a;
                        opa_next = t_a;
                        opb_next = t_a;
                        ret_next = S_P1;
                    end
                end
            end
            S_RUN: begin
                if (div_reg) begin
                    if (!dtrial[32]) acc_next = dtrial[31:0];
                    else             acc_next = dshift[31:0];
                    opb_next = {opb_reg[30:0], ~dtrial[32]};
                end else begin
                    if (opb_reg[0]) acc_next = acc_reg + opa_reg;
                    opa_next = {opa_reg[30:0], 1'b0};
                    opb_next = {1'b0, opb_reg[31:1]};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) state_next = ret_reg;
            end
            S_T1: begin
                t_a    = asr(acc_reg, 5'd15);
                x_next = t_a;
                t_b    = t_a + md;
                if (t_b == '0) begin
                    fault_next = 1'b1;
                    b5_next    = t_a;
                    val_next   = '0;
                    state_next = S_DONE;
                end else begin
                    t_c        = {mc[20:0], 11'd0};
                    neg_next   = t_c[31] ^ t_b[31];
                    opa_next   = mag(t_b);
                    opb_next   = mag(t_c);
                    acc_next   = '0;
                    cnt_next   = '0;
                    div_next   = 1'b1;
                    ret_next   = S_T2;
                    state_next = S_RUN;
                end
            end
            S_T2: begin
                t_a        = neg_reg ? (word_t'(0) - opb_reg) : opb_reg;
                t_b        = x_reg + t_a;
                b5_next    = t_b;
                val_next   = asr(t_b + 32'd8, 5'd4);
                state_next = S_DONE;
            end
            S_P1: begin
                y_next = asr(acc_reg, 5'd12);
                opa_next = b2; opb_next = asr(acc_reg, 5'd12);
                acc_next = '0; cnt_next = '0; ret_next = S_P2; state_next = S_RUN;
            end
            S_P2: begin
                z_next = asr(acc_reg, 5'd11);
                opa_next = ac2; opb_next = x_reg;
                acc_next = '0; cnt_next = '0; ret_next = S_P3; state_next = S_RUN;
            end
            S_P3: begin
                t_a    = z_reg + asr(acc_reg, 5'd11);
                t_b    = ({ac1[29:0], 2'b00} + t_a) << oss_reg;
                z_next = asr(t_b + 32'd2, 5'd2);                      // b3
                opa_next = ac3; opb_next = x_reg;
                acc_next = '0; cnt_next = '0; ret_next = S_P4; state_next = S_RUN;
            end
            S_P4: begin
                w_next = asr(acc_reg, 5'd13);
                opa_next = b1; opb_next = y_reg;
                acc_next = '0; cnt_next = '0; ret_next = S_P5; state_next = S_RUN;
            end
            S_P5: begin
                t_a = asr(w_reg + asr(acc_reg, 5'd16) + 32'd2, 5'd2);
                opa_next = ac4; opb_next = t_a + X3_OFFSET;
                acc_next = '0; cnt_next = '0; ret_next = S_P6; state_next = S_RUN;
            end
            S_P6: begin
                w_next   = {15'd0, acc_reg[31:15]};                  // b4
                opa_next = up - z_reg;
                opb_next = B7_SCALE >> oss_reg;
                acc_next = '0; cnt_next = '0; ret_next = S_P7; state_next = S_RUN;
            end
            S_P7: begin
                if (w_reg == '0) begin
                    fault_next = 1'b1;
                    val_next   = '0;
                    state_next = S_DONE;
                end else begin
                    // large b7 divides first, then doubles
                    neg_next   = acc_reg[31];
                    opb_next   = acc_reg[31] ? acc_reg : {acc_reg[30:0], 1'b0};
                    opa_next   = w_reg;
                    acc_next   = '0; cnt_next = '0; div_next = 1'b1;
                    ret_next   = S_P8; state_next = S_RUN;
                end
            end
            S_P8: begin
                t_a    = neg_reg ? {opb_reg[30:0], 1'b0} : opb_reg;
                x_next = t_a;
                opa_next = asr(t_a, 5'd8); opb_next = asr(t_a, 5'd8);
                acc_next = '0; cnt_next = '0; div_next = 1'b0;
                ret_next = S_P9; state_next = S_RUN;
            end
            S_P9: begin
                opa_next = acc_reg; opb_next = T1_COEF;
                acc_next = '0; cnt_next = '0; ret_next = S_P10; state_next = S_RUN;
            end
            S_P10: begin
                y_next = asr(acc_reg, 5'd16);
                opa_next = x_reg; opb_next = T2_COEF_NEG;
                acc_next = '0; cnt_next = '0; ret_next = S_P11; state_next = S_RUN;
            end
            S_P11: begin
                t_a        = y_reg + asr(acc_reg, 5'd16) + P_OFFSET;
                val_next   = x_reg + asr(t_a, 5'd4);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!ovld_reg || m_tready) begin
                    ovld_next  = 1'b1;
                    odata_next = val_reg;
                    ouser_next = {fault_reg, kind_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            ovld_reg  <= 1'b0;
            b5_reg    <= '0;
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ovld_reg  <= ovld_next;
            b5_reg    <= b5_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_CAL_A: cal_a_reg <= cfg_wdata;
                    CFG_CAL_B: cal_b_reg <= cfg_wdata;
                    CFG_CAL_C: cal_c_reg <= cfg_wdata[47:0];
                    CFG_OSS:   oss_reg   <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        div_reg   <= div_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        w_reg     <= w_next;
        neg_reg   <= neg_next;
        fault_reg <= fault_next;
        kind_reg  <= kind_next;
        raw_reg   <= raw_next;
        val_reg   <= val_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

endmodule

// File: dv/pressure_temperature_compensation_core_tb.sv
// Self-checking testbench for pressure_temperature_compensation_core.
// Predicts each compensated temperature/pressure beat in-line; depends on ptc_pkg.
`timescale 1ns / 100ps

module pressure_temperature_compensation_core_tb;
    import ptc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        fault;
    } comp_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;

    // predictor copy of registers and b5
    logic [63:0] cal_a, cal_b, cal_c;
    logic [1:0]  oss_setting;
    logic [31:0] b5_term;

    comp_result_t expected_q[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  burst_mode = 1'b1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pressure_temperature_compensation_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] sext(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        longint q;
        q = longint'($signed(a)) / longint'($signed(b));
        return q[31:0];
    endfunction

    // Compensation of one reading; updates the kept b5 on temperature beats
    function automatic comp_result_t compensate(input logic kind, input logic [23:0] raw);
        comp_result_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, dvs, up, b6, b6sq, b3, b4, b7, p, t1, t2;
        ac1 = sext(cal_a[63:48]); ac2 = sext(cal_a[47:32]);
        ac3 = sext(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
        ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
        b1 = sext(cal_b[31:16]); b2 = sext(cal_b[15:0]);
        mc = sext(cal_c[31:16]); md = sext(cal_c[15:0]);
        r.kind = kind;
        r.value = '0;
        r.fault = 1'b0;
        if (!kind) begin
            x1 = sra(({16'd0, raw[15:0]} - ac6) * ac5, 15);
            dvs = x1 + md;
            x2 = '0;
            if (dvs == 0) r.fault = 1'b1;
            else x2 = div_trunc(mc << 11, dvs);
            b5_term = x1 + x2;
            if (!r.fault) r.value = sra(b5_term + 32'd8, 4);
        end else begin
            up = {8'd0, raw} >> (8 - oss_setting);
            b6 = b5_term - B6_OFFSET;
            b6sq = sra(b6 * b6, 12);
            x3 = sra(b2 * b6sq, 11) + sra(ac2 * b6, 11);
            b3 = sra(((ac1 * 32'd4 + x3) << oss_setting) + 32'd2, 2);
            x3 = sra(sra(ac3 * b6, 13) + sra(b1 * b6sq, 16) + 32'd2, 2);
            b4 = (ac4 * (x3 + X3_OFFSET)) >> 15;
            b7 = (up - b3) * (B7_SCALE >> oss_setting);
            if (b4 == 0) begin
                r.fault = 1'b1;
            end else begin
                if (!b7[31]) p = (b7 * 32'd2) / b4;
                else p = (b7 / b4) * 32'd2;
                t1 = sra(p, 8);
                t1 = sra(t1 * t1 * T1_COEF, 16);
                t2 = sra(32'd0 - 32'd7357 * p, 16);
                p = p + sra(t1 + t2 + P_OFFSET, 4);
                r.value = p;
            end
        end
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat kind=%0b value=%0d fault=%0b", $time,
                         m_tuser[0], $signed(m_tdata), m_tuser[1]);
                fail_count++;
            end else begin
                comp_result_t e;
                e = expected_q.pop_front();
                if (e.kind !== m_tuser[0] || e.value !== m_tdata || e.fault !== m_tuser[1]) begin
                    $display("%0t: mismatch kind/value/fault exp %0b/%0d/%0b act %0b/%0d/%0b",
                             $time, e.kind, $signed(e.value), e.fault,
                             m_tuser[0], $signed(m_tdata), m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else if (burst_mode) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= 1'b1;
    end

    // watchdog on accepted beats
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** pressure_temperature_compensation_core: FAILED **");
            $finish;
        end
    end

    // tvalid goes low between beats; in burst mode the gap is sometimes longer
    task automatic send_reading(input logic kind, input logic [23:0] raw);
        int gap;
        gap = 1;
        if (burst_mode && $urandom_range(0, 7) == 0)
            gap = $urandom_range(2, 20);
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(compensate(kind, raw));
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_CAL_A: cal_a = data;
            CFG_CAL_B: cal_b = data;
            CFG_CAL_C: cal_c = data & 64'hFFFF_FFFF_FFFF;
            default:   oss_setting = data[1:0];
        endcase
    endtask

    task automatic load_cal(input logic [63:0] a, input logic [63:0] b,
                            input logic [63:0] c, input logic [1:0] oss);
        drain();
        write_reg(CFG_CAL_A, a);
        write_reg(CFG_CAL_B, b);
        write_reg(CFG_CAL_C, c);
        write_reg(CFG_OSS, {62'd0, oss});
        cfg_we <= 1'b0;
    endtask

    // typical datasheet coefficients
    task automatic load_typical(input logic [1:0] oss);
        load_cal({16'd408, -16'sd72, -16'sd14383, 16'd32741},
                 {16'd32757, 16'd23153, 16'd6190, 16'd4},
                 {16'h0000, 16'h8000, -16'sd8711, 16'd2868}, oss);
    endtask

    task automatic test_directed();
        // zero calibration: both divisors zero
        send_reading(1'b1, 24'hFFFFFF);
        send_reading(1'b0, 24'h000000);
        send_reading(1'b1, 24'h000000);
        load_typical(2'd0);
        send_reading(1'b0, 24'd27898);
        send_reading(1'b1, 24'd23843 << 8);
        send_reading(1'b0, 24'hFFFFFF);
        send_reading(1'b0, 24'h000000);
        send_reading(1'b1, 24'hFFFFFF);
        send_reading(1'b1, 24'h000000);   // b7 wraps negative: large-b7 path
        load_typical(2'd3);
        send_reading(1'b0, 24'd27898);
        send_reading(1'b1, 24'hFFFFFF);
        send_reading(1'b1, 24'h000000);
        // temperature divisor zero: x1 = 0, MD = 0
        load_cal(64'h0001_0000_0000_7FFF, 64'h0000_0000_0000_0000, 64'h0, 2'd1);
        send_reading(1'b0, 24'h001234);
        send_reading(1'b1, 24'h800000);
        // extreme coefficients
        load_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF, 2'd2);
        send_reading(1'b0, 24'hFFFFFF);
        send_reading(1'b1, 24'hFFFFFF);
        send_reading(1'b0, 24'h00FF00);
        send_reading(1'b1, 24'h0F0F0F);
    endtask

    task automatic random_phase(input int n, input bit typical);
        for (int i = 0; i < n; i++) begin
            logic kind;
            logic [23:0] raw;
            kind = 1'($urandom_range(0, 1));
            raw = 24'($urandom());
            // mostly realistic readings with typical calibration
            if (typical && $urandom_range(0, 3) != 0)
                raw = kind ? 24'((($urandom_range(20000, 40000)) << 8) | $urandom_range(0, 255))
                           : 24'($urandom_range(20000, 35000));
            send_reading(kind, raw);
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 12; ph++) begin
            if (ph % 3 == 0) load_typical(2'($urandom_range(0, 3)));
            else load_cal({$urandom(), $urandom()}, {$urandom(), $urandom()},
                          {$urandom(), $urandom()}, 2'($urandom_range(0, 3)));
            burst_mode = (ph % 4 != 1);
            random_phase(150, ph % 3 == 0);
        end
        burst_mode = 1'b1;
    endtask

    task automatic test_backpressure();
        load_typical(2'd1);
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_phase(20, 1'b1);
        join
        drain();   // sender pauses until all results are back
        random_phase(20, 1'b0);
    endtask

    initial begin
        cal_a = '0; cal_b = '0; cal_c = '0; oss_setting = '0; b5_term = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        drain();
        if (fail_count == 0)
            $display("** pressure_temperature_compensation_core: PASSED **");
        else
            $display("** pressure_temperature_compensation_core: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ptc_pkg.sv
hw/rtl/pressure_temperature_compensation_core.sv
dv/pressure_temperature_compensation_core_tb.sv
